// ===== sv/gpd_pkg.sv =====
// gpd_pkg: shared types and constants for the gaussian pyramid downsampler
// no dependencies; imported by every module of the block
`default_nettype none

package gpd_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_WIDTH_BITS  = 12;
    localparam int CFG_HEIGHT_BITS = 13;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

    // frame geometry
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_BITS   = 12;

    // line store ring: four source lines per column address
    localparam int LINES     = 4;
    localparam int LANE_BITS = 2;
    localparam int TAPS      = 5;

    // per-pixel flags that travel down the pipeline
    typedef struct packed {
        logic emit;
        logic eor;
        logic eof;
    } t_tag;

endpackage

`default_nettype wire

// ===== sv/gaussian_pyramid_downsample.sv =====
// gaussian_pyramid_downsample: 5x5 binomial filter with 2:1 decimation on a pixel stream
// top level: configuration, raster counters, pipeline control; uses gpd_line_store,
// gpd_filter and gpd_pkg
//
// usage:
//   source pixels enter in raster order on i_valid/o_ready/i_pixel_in, one per
//   transfer; filtered pixels leave on o_valid/i_ready with end_of_row and
//   end_of_frame flags. only interior output positions produce a result.
//   the configuration channel (i_cfg_valid/o_cfg_ready) writes image_width
//   (index 0) and image_height (index 1); either write restarts the frame.
//   write configuration only while no pixel is in flight.
// timing:
//   one pixel per cycle sustained while the pipeline does not stop. a result
//   passes memory read, column register, column weighting and window sum into
//   the output register. each pixel does one read-modify-write of its column
//   word in the line memory; a back-to-back pixel at the same column is forwarded.
// stall:
//   the output register holds a result until taken; the pipeline stops only
//   when a second result reaches the last stage while the output register is full.
// reset:
//   counters, window and pipeline valids clear; width 640, height 480. the line
//   memory is not cleared, every emitted window uses lines of the current frame.
`default_nettype none

module gaussian_pyramid_downsample
    import gpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire  [PIXEL_BITS-1:0]     i_pixel_in,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic [PIXEL_BITS-1:0]     o_pixel_out,
    output logic                      o_end_of_row,
    output logic                      o_end_of_frame,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire  [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire  [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = CW + 1;
    localparam int WCMP = (WW > CFG_WIDTH_BITS) ? WW : CFG_WIDTH_BITS;

    logic [CFG_WIDTH_BITS-1:0]  r_image_width;
    logic [CFG_HEIGHT_BITS-1:0] r_image_height;
    logic [CW-1:0]              r_col;
    logic [ROW_BITS-1:0]        r_row;

    logic [WCMP-1:0]            w_cfg;
    logic [WW-1:0]              eff_w;
    logic [CFG_HEIGHT_BITS-1:0] eff_h;
    logic [WW-1:0]              col_p1;
    logic [WW-1:0]              col_p2;
    logic [CFG_HEIGHT_BITS-1:0] row_p1;
    logic [CFG_HEIGHT_BITS-1:0] row_p2;
    logic                       last_col;
    logic                       last_row;
    t_tag                       tag;

    logic                       adv;
    logic                       fire;
    logic                       hold;
    logic                       cfg_hit;

    logic                            ls_valid;
    logic [TAPS-1:0][PIXEL_BITS-1:0] ls_col;
    t_tag                            ls_tag;

    // effective geometry: zero reads as one, oversize clamps to the maximum
    always_comb begin
        w_cfg = WCMP'(r_image_width);
        if (w_cfg == '0) begin
            eff_w = WW'(1);
        end else if (w_cfg > WCMP'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(w_cfg);
        end
        if (r_image_height == '0) begin
            eff_h = CFG_HEIGHT_BITS'(1);
        end else if (r_image_height > CFG_HEIGHT_BITS'(MAX_HEIGHT)) begin
            eff_h = CFG_HEIGHT_BITS'(MAX_HEIGHT);
        end else begin
            eff_h = r_image_height;
        end
    end

    always_comb begin
        col_p1   = WW'(r_col) + WW'(1);
        col_p2   = WW'(r_col) + WW'(2);
        row_p1   = CFG_HEIGHT_BITS'(r_row) + CFG_HEIGHT_BITS'(1);
        row_p2   = CFG_HEIGHT_BITS'(r_row) + CFG_HEIGHT_BITS'(2);
        last_col = col_p1 >= eff_w;
        last_row = row_p1 >= eff_h;
        // even positions from index 4 on, window fully inside the even-sized frame
        tag.emit = (r_row >= ROW_BITS'(4)) && (r_col >= CW'(4))
                && !r_row[0] && !r_col[0]
                && (row_p2 <= eff_h) && (col_p2 <= eff_w);
        tag.eor  = col_p2 == {eff_w[WW-1:1], 1'b0};
        tag.eof  = tag.eor && (row_p2 == {eff_h[CFG_HEIGHT_BITS-1:1], 1'b0});
    end

    assign adv         = !hold;
    assign o_ready     = adv;
    assign fire        = i_valid && adv;
    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid
                      && (i_cfg_index == REG_IMAGE_WIDTH || i_cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_WIDTH_BITS'(640);
            r_image_height <= CFG_HEIGHT_BITS'(480);
            r_col          <= '0;
            r_row          <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_image_width <= i_cfg_data[CFG_WIDTH_BITS-1:0];
            end else begin
                r_image_height <= i_cfg_data[CFG_HEIGHT_BITS-1:0];
            end
            r_col <= '0;
            r_row <= '0;
        end else if (fire) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : row_p1[ROW_BITS-1:0];
            end else begin
                r_col <= col_p1[CW-1:0];
            end
        end
    end

    gpd_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_fire  (fire),
        .i_addr  (r_col),
        .i_lane  (r_row[LANE_BITS-1:0]),
        .i_pixel (i_pixel_in),
        .i_tag   (tag),
        .o_valid (ls_valid),
        .o_col   (ls_col),
        .o_tag   (ls_tag)
    );

    gpd_filter #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (ls_valid),
        .i_col   (ls_col),
        .i_tag   (ls_tag),
        .i_ready (i_ready),
        .o_hold  (hold),
        .o_valid (o_valid),
        .o_pixel (o_pixel_out),
        .o_eor   (o_end_of_row),
        .o_eof   (o_end_of_frame)
    );

endmodule

`default_nettype wire

// ===== sv/gpd_line_store.sv =====
// gpd_line_store: four-line ring in one synchronous memory, one word per column
// read-modify-write per pixel with forwarding; needs gpd_pkg
`default_nettype none

module gpd_line_store
    import gpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_adv,
    input  wire                              i_fire,
    input  wire  [$clog2(MAX_WIDTH)-1:0]     i_addr,
    input  wire  [LANE_BITS-1:0]             i_lane,
    input  wire  [PIXEL_BITS-1:0]            i_pixel,
    input  t_tag                             i_tag,
    output logic                             o_valid,
    output logic [TAPS-1:0][PIXEL_BITS-1:0]  o_col,
    output t_tag                             o_tag
);

    localparam int AW = $clog2(MAX_WIDTH);

    typedef logic [LINES-1:0][PIXEL_BITS-1:0] t_word;

    t_word mem [MAX_WIDTH];

    t_word                 r_rd;
    t_word                 r_fwd_data;
    logic                  r_fwd;
    logic                  r_s1_valid;
    logic [AW-1:0]         r_s1_addr;
    logic [LANE_BITS-1:0]  r_s1_lane;
    logic [PIXEL_BITS-1:0] r_s1_pixel;
    t_tag                  r_s1_tag;

    t_word                               eff;
    t_word                               merged;
    logic [TAPS-1:0][PIXEL_BITS-1:0]     col;

    always_comb begin
        eff    = r_fwd ? r_fwd_data : r_rd;
        merged = eff;
        merged[r_s1_lane] = r_s1_pixel;
        for (int k = 0; k < LINES; k++) begin
            // oldest line first: slot (row + k) mod 4
            col[k] = eff[LANE_BITS'(r_s1_lane + LANE_BITS'(k))];
        end
        col[TAPS-1] = r_s1_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_s1_valid) begin
            mem[r_s1_addr] <= merged;
        end
        if (i_fire) begin
            r_rd <= mem[i_addr];
        end
    end

    // back-to-back transfer at the same column: memory still holds the old word
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_fwd_data <= merged;
            r_s1_addr  <= i_addr;
            r_s1_lane  <= i_lane;
            r_s1_pixel <= i_pixel;
            r_s1_tag   <= i_tag;
        end
        if (i_adv) begin
            o_col <= col;
            o_tag <= r_s1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd      <= 1'b0;
            r_s1_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else if (i_adv) begin
            r_fwd      <= i_fire && r_s1_valid && (r_s1_addr == i_addr);
            r_s1_valid <= i_fire;
            o_valid    <= r_s1_valid;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gpd_filter.sv =====
// gpd_filter: 5x5 binomial window as five column sums, horizontal sum, output register
// consumes columns from gpd_line_store; needs gpd_pkg
`default_nettype none

module gpd_filter
    import gpd_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_adv,
    input  wire                              i_valid,
    input  wire  [TAPS-1:0][PIXEL_BITS-1:0]  i_col,
    input  t_tag                             i_tag,
    input  wire                              i_ready,
    output logic                             o_hold,
    output logic                             o_valid,
    output logic [PIXEL_BITS-1:0]            o_pixel,
    output logic                             o_eor,
    output logic                             o_eof
);

    localparam int VW = PIXEL_BITS + 4;
    localparam int HW = PIXEL_BITS + 8;

    logic [TAPS-1:0][VW-1:0] r_win;
    logic                    r_s3_valid;
    t_tag                    r_s3_tag;

    logic [VW-1:0] vsum;
    logic [HW-1:0] hsum;

    // weights 1 4 6 4 1 as shifts and adds
    always_comb begin
        vsum = VW'(i_col[0]) + VW'(i_col[4])
             + (VW'(VW'(i_col[1]) + VW'(i_col[3])) << 2)
             + (VW'(i_col[2]) << 2) + (VW'(i_col[2]) << 1);
        hsum = HW'(r_win[0]) + HW'(r_win[4])
             + (HW'(HW'(r_win[1]) + HW'(r_win[3])) << 2)
             + (HW'(r_win[2]) << 2) + (HW'(r_win[2]) << 1);
    end

    assign o_hold = o_valid && r_s3_valid && r_s3_tag.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_s3_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (i_adv) begin
                if (i_valid) begin
                    r_win <= {vsum, r_win[TAPS-1:1]};
                end
                r_s3_valid <= i_valid;
            end
            if (i_adv && r_s3_valid && r_s3_tag.emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s3_tag <= i_tag;
        end
        if (i_adv && r_s3_valid && r_s3_tag.emit) begin
            o_pixel <= hsum[HW-1:8];
            o_eor   <= r_s3_tag.eor;
            o_eof   <= r_s3_tag.eof;
        end
    end

endmodule

`default_nettype wire

// ===== sim/gpd_checker.sv =====
// gpd_checker: scoreboard for the gaussian pyramid downsampler
// watches pixel, result and configuration transfers, predicts each filtered pixel
// and compares it with what leaves the block; depends on gpd_pkg
`default_nettype none

module gpd_checker
    import gpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_pix_valid,
    input  wire                       i_pix_ready,
    input  wire  [PIXEL_BITS-1:0]     i_pix,
    input  wire                       i_res_valid,
    input  wire                       i_res_ready,
    input  wire  [PIXEL_BITS-1:0]     i_res_pix,
    input  wire                       i_res_eor,
    input  wire                       i_res_eof,
    input  wire                       i_cfg_valid,
    input  wire                       i_cfg_ready,
    input  wire  [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire  [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                        o_errors,
    output int                        o_pending
);

    localparam int MAX_REPORTS = 10;
    localparam int unsigned BINOMIAL [TAPS] = '{1, 4, 6, 4, 1};

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        logic                  eor;
        logic                  eof;
    } t_down_pixel;

    t_down_pixel                expected_pixels [$];
    logic [PIXEL_BITS-1:0]      line_mem [LINES*MAX_WIDTH];
    logic [PIXEL_BITS-1:0]      win [TAPS][TAPS];
    int unsigned                col_pos;
    int unsigned                row_pos;
    logic [CFG_WIDTH_BITS-1:0]  width_reg;
    logic [CFG_HEIGHT_BITS-1:0] height_reg;
    int                         error_count;

    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("gpd_checker: %s", msg);
        end
    endtask

    // one source pixel through the line ring and window, maybe one filtered pixel out
    task automatic predict_pixel(input logic [PIXEL_BITS-1:0] px);
        int unsigned           w;
        int unsigned           h;
        int unsigned           r;
        int unsigned           c;
        int unsigned           acc;
        int unsigned           last_c;
        int unsigned           last_r;
        logic [PIXEL_BITS-1:0] column [TAPS];
        t_down_pixel           res;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        r = row_pos;
        c = col_pos;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;

        // rows r-4..r-1 live in the ring at (r+k) mod 4
        for (int k = 0; k < LINES; k++) begin
            column[k] = line_mem[((r + k) % LINES) * MAX_WIDTH + c];
        end
        column[TAPS-1] = px;
        line_mem[(r % LINES) * MAX_WIDTH + c] = px;
        for (int k = 0; k < TAPS; k++) begin
            for (int m = 0; m < TAPS - 1; m++) begin
                win[k][m] = win[k][m+1];
            end
            win[k][TAPS-1] = column[k];
        end

        last_c = 2 * (w / 2) - 2;
        last_r = 2 * (h / 2) - 2;
        if (r >= 4 && c >= 4 && r % 2 == 0 && c % 2 == 0 && r <= last_r && c <= last_c) begin
            acc = 0;
            for (int k = 0; k < TAPS; k++) begin
                for (int m = 0; m < TAPS; m++) begin
                    acc += BINOMIAL[k] * BINOMIAL[m] * win[k][m];
                end
            end
            res.pix = PIXEL_BITS'(acc >> 8);
            res.eor = (c == last_c);
            res.eof = (c == last_c) && (r == last_r);
            expected_pixels.push_back(res);
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_pixels.delete();
            for (int i = 0; i < LINES * MAX_WIDTH; i++) line_mem[i] = '0;
            for (int k = 0; k < TAPS; k++) begin
                for (int m = 0; m < TAPS; m++) win[k][m] = '0;
            end
            col_pos     = 0;
            row_pos     = 0;
            width_reg   = CFG_WIDTH_BITS'(640);
            height_reg  = CFG_HEIGHT_BITS'(480);
            error_count = 0;
        end else begin
            // results first: nothing accepted on this edge can already be out
            if (i_res_valid && i_res_ready) begin
                if (expected_pixels.size() == 0) begin
                    log_failure($sformatf("unexpected result: pix %0d eor %0b eof %0b",
                                          i_res_pix, i_res_eor, i_res_eof));
                end else begin
                    t_down_pixel want;
                    want = expected_pixels.pop_front();
                    if (want.pix !== i_res_pix || want.eor !== i_res_eor ||
                        want.eof !== i_res_eof) begin
                        log_failure($sformatf(
                            "mismatch: expected pix %0d eor %0b eof %0b, got pix %0d eor %0b eof %0b",
                            want.pix, want.eor, want.eof, i_res_pix, i_res_eor, i_res_eof));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_data[CFG_WIDTH_BITS-1:0];
                    col_pos   = 0;
                    row_pos   = 0;
                end else if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                    height_reg = i_cfg_data[CFG_HEIGHT_BITS-1:0];
                    col_pos    = 0;
                    row_pos    = 0;
                end
            end
            if (i_pix_valid && i_pix_ready) begin
                predict_pixel(i_pix);
            end
        end
        o_errors  <= error_count;
        o_pending <= expected_pixels.size();
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: stimulus and verdict for gaussian_pyramid_downsample
// drives pixel, result and configuration channels; gpd_checker does the scoring;
// depends on gpd_pkg, gpd_checker and the block
`default_nettype none

module tb;
    import gpd_pkg::*;

    localparam int PIX_BITS       = 8;
    localparam int MAX_W          = 2048;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 360;
    localparam int IDLE_PERCENT   = 18;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_TOP = '1;

    typedef enum {FILL_RANDOM, FILL_BLACK, FILL_WHITE, FILL_BINARY} t_fill;

    logic                      clk;
    logic                      rst_n        = 1'b0;
    logic                      pix_valid    = 1'b0;
    logic                      pix_ready;
    logic [PIX_BITS-1:0]       pix_data     = '0;
    logic                      res_valid;
    logic                      res_ready    = 1'b0;
    logic [PIX_BITS-1:0]       res_pixel;
    logic                      res_eor;
    logic                      res_eof;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                      calm         = 1'b0;
    logic                      hold_trigger = 1'b0;
    int                        chk_errors;
    int                        chk_pending;

    gaussian_pyramid_downsample #(
        .MAX_WIDTH  (MAX_W),
        .PIXEL_BITS (PIX_BITS)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (pix_valid),
        .o_ready        (pix_ready),
        .i_pixel_in     (pix_data),
        .o_valid        (res_valid),
        .i_ready        (res_ready),
        .o_pixel_out    (res_pixel),
        .o_end_of_row   (res_eor),
        .o_end_of_frame (res_eof),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    gpd_checker #(
        .MAX_WIDTH  (MAX_W),
        .PIXEL_BITS (PIX_BITS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix_valid (pix_valid),
        .i_pix_ready (pix_ready),
        .i_pix       (pix_data),
        .i_res_valid (res_valid),
        .i_res_ready (res_ready),
        .i_res_pix   (res_pixel),
        .i_res_eor   (res_eor),
        .i_res_eof   (res_eof),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random stalls, one long hold-off while the sender keeps going
    initial begin : receiver
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_trigger && !held) begin
                held = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (pix_valid && pix_ready) || (res_valid && res_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: done, errors");
        $finish;
    end

    task automatic send_pixel(input logic [PIX_BITS-1:0] px);
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
    endtask

    task automatic feed(input int unsigned count, input t_fill fill);
        logic [PIX_BITS-1:0] px;
        for (int unsigned n = 0; n < count; n++) begin
            case (fill)
                FILL_BLACK:  px = '0;
                FILL_WHITE:  px = '1;
                FILL_BINARY: px = $urandom_range(0, 1) ? '1 : '0;
                default:     px = PIX_BITS'($urandom);
            endcase
            send_pixel(px);
        end
    endtask

    // stop sending and wait until every filtered pixel is out and the pipe is empty
    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no low cycle; caller lowers it
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // unused upper data bits get random junk
    task automatic set_geometry(input int unsigned w, input int unsigned h);
        settle();
        write_reg(REG_IMAGE_WIDTH,
                  {(CFG_DATA_BITS-CFG_WIDTH_BITS)'($urandom), CFG_WIDTH_BITS'(w)});
        write_reg(REG_IMAGE_HEIGHT,
                  {(CFG_DATA_BITS-CFG_HEIGHT_BITS)'($urandom), CFG_HEIGHT_BITS'(h)});
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned random_fed;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        t_fill       fill;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry 640x480: too few rows for any result yet
        feed(64, FILL_RANDOM);

        // smallest frame, saturated and dark
        set_geometry(6, 6);
        feed(36, FILL_WHITE);
        feed(36, FILL_BLACK);

        // writes to unmapped indexes must not restart the frame
        set_geometry(8, 8);
        feed(30, FILL_RANDOM);
        settle();
        write_reg(REG_UNMAPPED_TOP, '1);
        write_reg(CFG_INDEX_BITS'($urandom_range(REG_IMAGE_HEIGHT + 1, REG_UNMAPPED_TOP)),
                  CFG_DATA_BITS'($urandom));
        cfg_valid <= 1'b0;
        feed(34 + 64, FILL_RANDOM);

        // images too small for any output, zero sizes too
        set_geometry(5, 480);
        feed(60, FILL_RANDOM);
        set_geometry(6, 5);
        feed(60, FILL_RANDOM);
        set_geometry(0, 6);
        feed(20, FILL_RANDOM);
        set_geometry(8, 0);
        feed(20, FILL_RANDOM);

        // odd sizes drop the last row and column
        set_geometry(7, 9);
        feed(63 * 2, FILL_RANDOM);

        // result side held off long enough to back up the input
        set_geometry(12, 14);
        hold_trigger <= 1'b1;
        feed(12 * 14, FILL_RANDOM);

        random_fed = 0;
        while (random_fed < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 12) begin
                w = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(6, 24);
                h = (w >= 6) ? $urandom_range(0, 5) : $urandom_range(0, 20);
                set_geometry(w, h);
                feed($urandom_range(1, 40), FILL_RANDOM);
            end else begin
                w = $urandom_range(6, 24);
                h = $urandom_range(6, 14);
                case ($urandom_range(0, 9))
                    0:       fill = FILL_WHITE;
                    1:       fill = FILL_BLACK;
                    2:       fill = FILL_BINARY;
                    default: fill = FILL_RANDOM;
                endcase
                // mostly whole frames, some cut short by the next reconfiguration
                if ($urandom_range(0, 99) < 70) n = w * h * $urandom_range(1, 2);
                else n = $urandom_range(1, w * h);
                set_geometry(w, h);
                feed(n, fill);
                random_fed += n;
            end
        end

        // one frame at full rate on both sides, running into the next
        calm <= 1'b1;
        set_geometry(16, 12);
        feed(16 * 12 + 40, FILL_RANDOM);
        calm <= 1'b0;

        settle();
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/gpd_pkg.sv
sv/gpd_line_store.sv
sv/gpd_filter.sv
sv/gaussian_pyramid_downsample.sv
sim/gpd_checker.sv
sim/tb.sv
